### hdl/sdtq_pkg.sv
`default_nettype none
package sdtq_pkg;

	localparam logic [31:0] HALF_RANGE = 32'hFFFF_FFFF >> 1;

	localparam logic [2:0] FUNC_SET    = 3'd0;
	localparam logic [2:0] FUNC_INSERT = 3'd1;
	localparam logic [2:0] FUNC_REMOVE = 3'd2;
	localparam logic [2:0] FUNC_QUERY  = 3'd3;
	localparam logic [2:0] FUNC_RUN    = 3'd4;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_QUEUED     = 2'd1;
	localparam logic [1:0] STATUS_NOT_QUEUED = 2'd2;

	typedef struct packed {
		logic [2:0]  func;
		logic [3:0]  timer_id;
		logic [31:0] deadline;
		logic [31:0] now_tick;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        expired_valid;
		logic [3:0]  expired_id;
		logic [31:0] timeout;
		logic        queued;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [3:0]  id;
		logic [31:0] dl;
	} ord_entry_t;

	function automatic logic tick_before(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d > HALF_RANGE;
	endfunction

	function automatic logic [31:0] calc_timeout(input logic [31:0] when,
		input logic [31:0] now);
		logic [31:0] t;
		t = when - now;
		return (t > HALF_RANGE) ? 32'd0 : t;
	endfunction

endpackage
`default_nettype wire

### hdl/sdtq_order_ram.sv
`default_nettype none
module sdtq_order_ram #(
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  wire logic                    clk,
	input  wire logic                    we,
	input  wire logic [AW-1:0]           waddr,
	input  wire sdtq_pkg::ord_entry_t    wdata,
	input  wire logic [AW-1:0]           raddr,
	output sdtq_pkg::ord_entry_t         rdata
);
	import sdtq_pkg::*;

	ord_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### hdl/sdtq_deadline_store.sv
`default_nettype none
module sdtq_deadline_store #(
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [31:0]       wdata,
	input  wire logic [AW-1:0]     raddr,
	output logic [31:0]            rdata
);
	logic [31:0]      mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [31:0]      rd_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rd_vld_q <= vld_q[raddr];
		end
	end

	assign rdata = rd_vld_q ? rd_q : 32'd0;

endmodule
`default_nettype wire

### hdl/sorted_deadline_timer_queue_unit.sv
`default_nettype none
// Sorted timer queue. A command is transferred when start is high and busy is low; it
// carries func, timer_id, deadline and now_tick. Each result appears on rsp for one
// cycle with rsp_valid high, and the final result of a command has rsp.last set.
// The receiver cannot hold results off, so the block never waits on the output side.
// The queue lives in a memory of id and deadline pairs with one read and one write
// port, and each entry that a command visits is handled in a read state that presents the
// address and then an evaluate state that uses the registered read data.
// Set deadline, unknown codes and refused commands answer in the cycle after the transfer,
// as do query and run on an empty queue. Otherwise query reads the head of the queue.
// Insert fetches the stored deadline, walks the entries and writes the last one at the
// end; remove walks every entry. A run that expires k timers scans from the head until
// an entry has not expired, reports each expired timer and moves the remaining entries
// down to the head; its k expiry results come before the final one.
// busy stays high until the final result is shown, and one command is worked at a time.
// Reset clears the queue count, the queued flags and the valid bits of the deadline
// table; the queue memory needs no clearing pass and the block is ready at once.
module sorted_deadline_timer_queue_unit #(
	parameter int NUM_TIMERS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire sdtq_pkg::cmd_t cmd,
	output logic                busy,
	output logic                rsp_valid,
	output sdtq_pkg::rsp_t      rsp
);
	import sdtq_pkg::*;

	localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CW = $clog2(NUM_TIMERS + 1);
	localparam int XW = (AW > 4) ? AW : 4;

	typedef enum logic [3:0] {
		IDLE, INS_DL, INS_RD, INS_EV, INS_END, RM_RD, RM_EV, Q_RD, Q_EV,
		RN_RD, RN_EV, EM_RD, EM_EV, CP_RD, CP_EV, FIN
	} state_t;

	state_t             state_q;
	cmd_t               cmd_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      j_q;
	logic [CW-1:0]      k_q;
	logic [NUM_TIMERS-1:0] flag_q;
	logic               found_q;
	ord_entry_t         carry_q;
	logic [31:0]        tout_q;

	ord_entry_t         ord_rdata;
	ord_entry_t         ord_wdata;
	logic               ord_we;
	logic [AW-1:0]      ord_waddr;
	logic [31:0]        dl_rdata;

	logic [XW-1:0]      cid_x;
	logic [XW-1:0]      qid_x;
	logic [XW-1:0]      eid_x;
	logic [AW-1:0]      cidx;
	logic [AW-1:0]      qidx;
	logic [AW-1:0]      eidx;
	logic               cslot;
	logic               qslot;
	logic               q_now;
	logic               c_flag;
	logic               ev_last;
	logic               em_last;
	logic               ins_take;
	logic               rm_match;
	logic [31:0]        e_tout;

	assign cid_x = XW'(cmd.timer_id);
	assign qid_x = XW'(cmd_q.timer_id);
	assign eid_x = XW'(ord_rdata.id);
	assign cidx  = cid_x[AW-1:0];
	assign qidx  = qid_x[AW-1:0];
	assign eidx  = eid_x[AW-1:0];
	assign cslot = 7'(cmd.timer_id) < 7'(NUM_TIMERS);
	assign qslot = 7'(cmd_q.timer_id) < 7'(NUM_TIMERS);
	assign c_flag = cslot && flag_q[cidx];
	assign q_now  = qslot && flag_q[qidx];

	assign ev_last  = CW'(j_q + 1'b1) == cnt_q;
	assign em_last  = CW'(j_q + 1'b1) == k_q;
	assign ins_take = found_q || !tick_before(ord_rdata.dl, cmd_q.deadline);
	assign rm_match = ord_rdata.id == cmd_q.timer_id;
	assign e_tout   = calc_timeout(ord_rdata.dl, cmd_q.now_tick);

	assign busy = state_q != IDLE;

	always_comb begin
		ord_we = 1'b0;
		ord_waddr = j_q[AW-1:0];
		ord_wdata = carry_q;
		case (state_q)
			INS_EV: begin
				ord_we = ins_take;
			end
			INS_END: begin
				ord_we = 1'b1;
				ord_waddr = cnt_q[AW-1:0];
			end
			RM_EV: begin
				ord_we = found_q;
				ord_waddr = AW'(j_q - 1'b1);
				ord_wdata = ord_rdata;
			end
			CP_EV: begin
				ord_we = 1'b1;
				ord_waddr = AW'(j_q - k_q);
				ord_wdata = ord_rdata;
			end
			default: begin
				ord_we = 1'b0;
			end
		endcase
	end

	sdtq_order_ram #(
		.DEPTH(NUM_TIMERS),
		.AW(AW)
	) u_order (
		.clk(clk),
		.we(ord_we),
		.waddr(ord_waddr),
		.wdata(ord_wdata),
		.raddr(j_q[AW-1:0]),
		.rdata(ord_rdata)
	);

	sdtq_deadline_store #(
		.DEPTH(NUM_TIMERS),
		.AW(AW)
	) u_deadline (
		.clk(clk),
		.arst_n(arst_n),
		.we(state_q == IDLE && start && cmd.func == FUNC_SET && cslot && !c_flag),
		.waddr(cidx),
		.wdata(cmd.deadline),
		.raddr(cidx),
		.rdata(dl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q <= '0;
			flag_q <= '0;
			rsp_valid <= 1'b0;
			rsp <= '0;
			cmd_q <= '0;
			carry_q <= '0;
			tout_q <= '0;
			j_q <= '0;
			k_q <= '0;
			found_q <= 1'b0;
		end else begin
			rsp_valid <= 1'b0;
			case (state_q)
				IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						j_q <= '0;
						found_q <= 1'b0;
						rsp <= '{status: STATUS_OK, expired_valid: 1'b0, expired_id: 4'd0,
							timeout: 32'd0, queued: c_flag, last: 1'b1};
						case (cmd.func)
							FUNC_SET: begin
								rsp_valid <= 1'b1;
								if (!cslot) begin
									rsp.status <= STATUS_NOT_QUEUED;
								end else if (c_flag) begin
									rsp.status <= STATUS_QUEUED;
								end
							end
							FUNC_INSERT: begin
								if (!cslot) begin
									rsp_valid <= 1'b1;
									rsp.status <= STATUS_NOT_QUEUED;
								end else if (c_flag) begin
									rsp_valid <= 1'b1;
									rsp.status <= STATUS_QUEUED;
								end else if (cnt_q == CW'(NUM_TIMERS)) begin
									rsp_valid <= 1'b1;
								end else begin
									state_q <= INS_DL;
								end
							end
							FUNC_REMOVE: begin
								if (!c_flag) begin
									rsp_valid <= 1'b1;
									rsp.status <= STATUS_NOT_QUEUED;
								end else begin
									state_q <= RM_RD;
								end
							end
							FUNC_QUERY: begin
								if (cnt_q == '0) begin
									rsp_valid <= 1'b1;
									rsp.timeout <= '1;
								end else begin
									state_q <= Q_RD;
								end
							end
							FUNC_RUN: begin
								if (cnt_q == '0) begin
									rsp_valid <= 1'b1;
									rsp.timeout <= '1;
								end else begin
									state_q <= RN_RD;
								end
							end
							default: begin
								rsp_valid <= 1'b1;
							end
						endcase
					end
				end
				INS_DL: begin
					cmd_q.deadline <= dl_rdata;
					carry_q <= '{id: cmd_q.timer_id, dl: dl_rdata};
					state_q <= (cnt_q == '0) ? INS_END : INS_RD;
				end
				INS_RD: begin
					state_q <= INS_EV;
				end
				INS_EV: begin
					if (ins_take) begin
						carry_q <= ord_rdata;
						found_q <= 1'b1;
					end
					j_q <= CW'(j_q + 1'b1);
					state_q <= ev_last ? INS_END : INS_RD;
				end
				INS_END: begin
					cnt_q <= CW'(cnt_q + 1'b1);
					flag_q[qidx] <= 1'b1;
					rsp_valid <= 1'b1;
					rsp.queued <= 1'b1;
					state_q <= IDLE;
				end
				RM_RD: begin
					state_q <= RM_EV;
				end
				RM_EV: begin
					if (rm_match) begin
						found_q <= 1'b1;
					end
					j_q <= CW'(j_q + 1'b1);
					if (ev_last) begin
						if (found_q || rm_match) begin
							cnt_q <= CW'(cnt_q - 1'b1);
						end
						flag_q[qidx] <= 1'b0;
						rsp_valid <= 1'b1;
						rsp.queued <= 1'b0;
						state_q <= IDLE;
					end else begin
						state_q <= RM_RD;
					end
				end
				Q_RD: begin
					state_q <= Q_EV;
				end
				Q_EV: begin
					rsp_valid <= 1'b1;
					rsp.timeout <= e_tout;
					state_q <= IDLE;
				end
				RN_RD: begin
					state_q <= RN_EV;
				end
				RN_EV: begin
					if (e_tout == 32'd0) begin
						flag_q[eidx] <= 1'b0;
						if (ev_last) begin
							k_q <= cnt_q;
							tout_q <= '1;
							j_q <= '0;
							state_q <= EM_RD;
						end else begin
							j_q <= CW'(j_q + 1'b1);
							state_q <= RN_RD;
						end
					end else begin
						k_q <= j_q;
						tout_q <= e_tout;
						j_q <= '0;
						state_q <= (j_q == '0) ? FIN : EM_RD;
					end
				end
				EM_RD: begin
					state_q <= EM_EV;
				end
				EM_EV: begin
					rsp_valid <= 1'b1;
					rsp <= '{status: STATUS_OK, expired_valid: 1'b1, expired_id: ord_rdata.id,
						timeout: 32'd0, queued: q_now, last: 1'b0};
					j_q <= CW'(j_q + 1'b1);
					if (em_last) begin
						state_q <= (k_q == cnt_q) ? FIN : CP_RD;
					end else begin
						state_q <= EM_RD;
					end
				end
				CP_RD: begin
					state_q <= CP_EV;
				end
				CP_EV: begin
					j_q <= CW'(j_q + 1'b1);
					state_q <= ev_last ? FIN : CP_RD;
				end
				FIN: begin
					cnt_q <= CW'(cnt_q - k_q);
					rsp_valid <= 1'b1;
					rsp <= '{status: STATUS_OK, expired_valid: 1'b0, expired_id: 4'd0,
						timeout: tout_q, queued: q_now, last: 1'b1};
					state_q <= IDLE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/sdtq_checker.sv
`default_nettype none
module sdtq_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           start,
	input wire sdtq_pkg::cmd_t cmd,
	input wire logic           busy,
	input wire logic           rsp_valid,
	input wire sdtq_pkg::rsp_t rsp
);
	import sdtq_pkg::*;

	// A command that still owes results keeps the block busy.
	a_pending_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> busy)
		else $error("busy low while results are pending");

	// Every command ends with its final transfer on the edge where busy falls.
	a_fall_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> rsp_valid && rsp.last)
		else $error("busy fell without a final result");

	a_expired_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.expired_valid |-> !rsp.last && rsp.status == STATUS_OK
			&& rsp.timeout == 32'd0)
		else $error("malformed expiry result");

	a_queued_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STATUS_QUEUED |-> rsp.queued && rsp.last)
		else $error("already-queued status without queued flag");

	// A set deadline transfer is answered in the next cycle.
	a_set_answer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.func == FUNC_SET |=> rsp_valid && rsp.last)
		else $error("set deadline not answered in the next cycle");

endmodule

bind sorted_deadline_timer_queue_unit sdtq_checker u_sdtq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.cmd(cmd),
	.busy(busy),
	.rsp_valid(rsp_valid),
	.rsp(rsp)
);
`default_nettype wire
